// ===== src/mbau_pkg.sv =====
// Shared types, constants and helpers for the 50-bit modular Barrett ALU.
// Used by every module of the block.
package mbau_pkg;

    localparam int DIGIT_BITS = 52;
    localparam int RES_BITS   = 50;
    localparam int WORD_BITS  = 64;
    localparam int PROD_BITS  = 2 * DIGIT_BITS;
    localparam int NSTG       = 17;

    localparam logic [3:0] MODE_MUL        = 4'd0;
    localparam logic [3:0] MODE_MUL_ADD    = 4'd1;
    localparam logic [3:0] MODE_MUL_SUB    = 4'd2;
    localparam logic [3:0] MODE_ADD        = 4'd3;
    localparam logic [3:0] MODE_SUB        = 4'd4;
    localparam logic [3:0] MODE_NEG        = 4'd5;
    localparam logic [3:0] MODE_RED64      = 4'd6;
    localparam logic [3:0] MODE_RED_SIGNED = 4'd7;
    localparam logic [3:0] MODE_RED_WIDE   = 4'd8;

    localparam logic [2:0] CFG_MODULUS  = 3'd0;
    localparam logic [2:0] CFG_FACTOR   = 3'd1;
    localparam logic [2:0] CFG_SHIFT    = 3'd2;
    localparam logic [2:0] CFG_FOLD_ONE = 3'd3;
    localparam logic [2:0] CFG_FOLD_TWO = 3'd4;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic [3:0]          mode;
        logic                last;
        logic                neg;
        logic [RES_BITS-1:0] acc;
        logic [RES_BITS-1:0] simple;
    } t_side;

    // subtract q when that does not wrap
    function automatic logic [WORD_BITS-1:0] f_min_sub(input logic [WORD_BITS-1:0] v,
                                                       input logic [RES_BITS-1:0] q);
        logic [WORD_BITS-1:0] w;
        w = v - {{(WORD_BITS-RES_BITS){1'b0}}, q};
        return (w < v) ? w : v;
    endfunction

endpackage

// ===== src/mbau_mul.sv =====
// Two-stage 52x52 multiplier: four 26x26 partial products, then one sum.
// Depends on mbau_pkg.
module mbau_mul import mbau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en_pp,
    input  logic                  i_en_sum,
    input  logic [DIGIT_BITS-1:0] i_x,
    input  logic [DIGIT_BITS-1:0] i_y,
    output logic [PROD_BITS-1:0]  o_p
);
    localparam int HB = DIGIT_BITS / 2;

    logic [2*HB-1:0]     r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [PROD_BITS-1:0] r_p;
    logic [2*HB:0]        w_mid;

    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_pp_ll <= i_x[HB-1:0] * i_y[HB-1:0];
            r_pp_lh <= i_x[HB-1:0] * i_y[2*HB-1:HB];
            r_pp_hl <= i_x[2*HB-1:HB] * i_y[HB-1:0];
            r_pp_hh <= i_x[2*HB-1:HB] * i_y[2*HB-1:HB];
        end
    end

    assign w_mid = {1'b0, r_pp_lh} + {1'b0, r_pp_hl};

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_p <= {r_pp_hh, r_pp_ll} + {{(HB-1){1'b0}}, w_mid, {HB{1'b0}}};
        end
    end

    assign o_p = r_p;
endmodule

// ===== src/mbau_ctl.sv =====
// Valid chain and per-stage load enables; a stage loads when it is empty
// or its word moves on. Depends on mbau_pkg.
module mbau_ctl import mbau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_stall,
    output t_pipe_ctl o_ctl
);
    logic [NSTG-1:0] r_vld, n_vld, w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NSTG; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en  = w_en;
    assign o_ctl.vld = r_vld;
endmodule

// ===== src/modq_barrett_alu_50bit_unit.sv =====
// Modular ALU mod q < 2^50: multiply / mac / add / sub / negate / reductions.
// One word per cycle sustained while the output is not stalled, through the
// 17-stage pipeline with six two-stage 52x52 multipliers, five of them in series.
// Stalled stages hold; empty stages fill, so input is taken while output waits.
// Reset (sync, active low) empties the pipe and loads the register defaults.
module modq_barrett_alu_50bit_unit import mbau_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [3:0]            i_mode,
    input  logic [WORD_BITS-1:0]  i_op_a,
    input  logic [WORD_BITS-1:0]  i_op_b,
    input  logic [RES_BITS-1:0]   i_acc,
    input  logic                  i_last_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [RES_BITS-1:0]   o_result,
    output logic                  o_last_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [DIGIT_BITS-1:0] i_cfg_data
);
    t_pipe_ctl w_ctl;

    logic [RES_BITS-1:0]   r_modulus, r_fold_one, r_fold_two;
    logic [DIGIT_BITS-1:0] r_factor;
    logic [5:0]            r_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= RES_BITS'(2);
            r_factor   <= '0;
            r_shift    <= '0;
            r_fold_one <= '0;
            r_fold_two <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODULUS:  r_modulus  <= i_cfg_data[RES_BITS-1:0];
                CFG_FACTOR:   r_factor   <= i_cfg_data;
                CFG_SHIFT:    r_shift    <= i_cfg_data[5:0];
                CFG_FOLD_ONE: r_fold_one <= i_cfg_data[RES_BITS-1:0];
                CFG_FOLD_TWO: r_fold_two <= i_cfg_data[RES_BITS-1:0];
                default: ;
            endcase
        end
    end

    mbau_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (w_ctl)
    );

    assign o_in_stall = !w_ctl.en[0];

    // ---------------- stage 0: operand prep, simple add/sub
    t_side                 r_side [NSTG];
    t_side                 w_side0, w_side1;
    logic                  w_wide0, w_neg0;
    logic [WORD_BITS-1:0]  r0_sum, r0_dif, r0_v, r1_v;
    logic [DIGIT_BITS-1:0] r0_x0, r1_x0;
    logic [DIGIT_BITS-1:0] w_m1_x, w_m1_y, w_m2_x, w_m2_y;
    logic [PROD_BITS-1:0]  w_p1, w_p2, w_pb, w_pc, w_pe, w_pf;
    logic [DIGIT_BITS-1:0] w_qn;

    assign w_wide0 = (i_mode == MODE_RED_WIDE);
    assign w_neg0  = (i_mode == MODE_RED_SIGNED) && i_op_a[WORD_BITS-1];
    // top digit of the 128-bit value is only 24 bits wide
    assign w_m1_x  = w_wide0 ? {28'd0, i_op_b[WORD_BITS-1:PROD_BITS-WORD_BITS]}
                             : i_op_a[DIGIT_BITS-1:0];
    assign w_m1_y  = w_wide0 ? {2'b0, r_fold_two} : i_op_b[DIGIT_BITS-1:0];
    // middle digit spans the top of op_a and the low 40 bits of op_b
    assign w_m2_x  = {i_op_b[PROD_BITS-WORD_BITS-1:0], i_op_a[WORD_BITS-1:DIGIT_BITS]};
    assign w_m2_y  = {2'b0, r_fold_one};
    assign w_qn    = DIGIT_BITS'(0) - {2'b0, r_modulus};

    always_comb begin
        w_side0.mode   = i_mode;
        w_side0.last   = i_last_in;
        w_side0.neg    = w_neg0;
        w_side0.acc    = i_acc;
        w_side0.simple = (i_op_a == '0) ? '0 : (r_modulus - i_op_a[RES_BITS-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r0_x0  <= i_op_a[DIGIT_BITS-1:0];
            r0_sum <= i_op_a + i_op_b;
            r0_dif <= i_op_a - i_op_b;
            r0_v   <= w_neg0 ? (WORD_BITS'(0) - i_op_a) : i_op_a;
        end
    end

    mbau_mul u_mul_a (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[0]), .i_en_sum(w_ctl.en[1]),
        .i_x(w_m1_x), .i_y(w_m1_y), .o_p(w_p1)
    );
    mbau_mul u_mul_mid (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[0]), .i_en_sum(w_ctl.en[1]),
        .i_x(w_m2_x), .i_y(w_m2_y), .o_p(w_p2)
    );

    // ---------------- stage 1: finish add/sub
    logic [WORD_BITS-1:0] w_add1;

    always_comb begin
        w_side1 = r_side[0];
        w_add1  = f_min_sub(r0_sum, r_modulus);
        case (r_side[0].mode)
            MODE_ADD: w_side1.simple = w_add1[RES_BITS-1:0];
            MODE_SUB: w_side1.simple = r0_dif[WORD_BITS-1]
                                     ? (r0_dif[RES_BITS-1:0] + r_modulus)
                                     : r0_dif[RES_BITS-1:0];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[1]) begin
            r1_x0 <= r0_x0;
            r1_v  <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) r_side[0] <= w_side0;
        if (w_ctl.en[1]) r_side[1] <= w_side1;
        for (int k = 2; k < NSTG; k++) begin
            if (w_ctl.en[k]) r_side[k] <= r_side[k-1];
        end
    end

    // ---------------- stage 2: split into high/low digits
    logic [DIGIT_BITS+1:0] w_sl2;
    logic [DIGIT_BITS-1:0] w_sh2;
    logic [DIGIT_BITS-1:0] r2_h, r2_l, r3_h, r3_l, r4_h, r4_l;

    assign w_sl2 = {2'b0, r1_x0} + {2'b0, w_p2[DIGIT_BITS-1:0]} + {2'b0, w_p1[DIGIT_BITS-1:0]};
    assign w_sh2 = w_p2[PROD_BITS-1:DIGIT_BITS] + w_p1[PROD_BITS-1:DIGIT_BITS]
                 + {{(DIGIT_BITS-2){1'b0}}, w_sl2[DIGIT_BITS+1:DIGIT_BITS]};

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[2]) begin
            case (r_side[1].mode)
                MODE_RED_WIDE: begin
                    r2_h <= w_sh2;
                    r2_l <= w_sl2[DIGIT_BITS-1:0];
                end
                MODE_RED64, MODE_RED_SIGNED: begin
                    r2_h <= {{(2*DIGIT_BITS-WORD_BITS){1'b0}}, r1_v[WORD_BITS-1:DIGIT_BITS]};
                    r2_l <= r1_v[DIGIT_BITS-1:0];
                end
                default: begin
                    r2_h <= w_p1[PROD_BITS-1:DIGIT_BITS];
                    r2_l <= w_p1[DIGIT_BITS-1:0];
                end
            endcase
        end
        if (w_ctl.en[3]) begin
            r3_h <= r2_h;
            r3_l <= r2_l;
        end
        if (w_ctl.en[4]) begin
            r4_h <= r3_h;
            r4_l <= r3_l;
        end
    end

    // ---------------- stages 3..7: two folds by 2^52 mod q
    mbau_mul u_mul_fold1 (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[3]), .i_en_sum(w_ctl.en[4]),
        .i_x(r2_h), .i_y({2'b0, r_fold_one}), .o_p(w_pb)
    );
    mbau_mul u_mul_fold2 (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[5]), .i_en_sum(w_ctl.en[6]),
        .i_x(w_pb[PROD_BITS-1:DIGIT_BITS]), .i_y({2'b0, r_fold_one}), .o_p(w_pc)
    );

    logic [DIGIT_BITS-1:0] r5_h, r6_h, r7_h, r7_l;
    logic [DIGIT_BITS+1:0] r5_l, r6_l;
    logic [DIGIT_BITS+2:0] w_t7;
    logic                  w_wide4, w_wide6;

    assign w_wide4 = (r_side[4].mode == MODE_RED_WIDE);
    assign w_wide6 = (r_side[6].mode == MODE_RED_WIDE);
    assign w_t7    = {1'b0, r6_l} + {3'b0, w_pc[DIGIT_BITS-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[5]) begin
            r5_h <= r4_h;
            r5_l <= w_wide4 ? ({2'b0, r4_l} + {2'b0, w_pb[DIGIT_BITS-1:0]}) : {2'b0, r4_l};
        end
        if (w_ctl.en[6]) begin
            r6_h <= r5_h;
            r6_l <= r5_l;
        end
        if (w_ctl.en[7]) begin
            if (w_wide6) begin
                r7_h <= w_pc[PROD_BITS-1:DIGIT_BITS]
                      + {{(DIGIT_BITS-3){1'b0}}, w_t7[DIGIT_BITS+2:DIGIT_BITS]};
                r7_l <= w_t7[DIGIT_BITS-1:0];
            end else begin
                r7_h <= r6_h;
                r7_l <= r6_l[DIGIT_BITS-1:0];
            end
        end
    end

    // ---------------- stage 8: quotient source by barrel shift
    logic [PROD_BITS-1:0]  w_x8;
    logic                  w_word7;
    logic [DIGIT_BITS-1:0] r8_c, r8_l, r9_l, r10_l, r11_l, r12_l, r13_r, r14_p;

    assign w_x8    = {r7_h, r7_l} >> r_shift;
    assign w_word7 = (r_side[7].mode == MODE_RED64) || (r_side[7].mode == MODE_RED_SIGNED);

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[8]) begin
            // split values give zero once the shift passes the digit width
            r8_c <= (!w_word7 && r_shift > 6'(DIGIT_BITS)) ? '0 : w_x8[DIGIT_BITS-1:0];
            r8_l <= r7_l;
        end
        if (w_ctl.en[9])  r9_l  <= r8_l;
        if (w_ctl.en[10]) r10_l <= r9_l;
        if (w_ctl.en[11]) r11_l <= r10_l;
        if (w_ctl.en[12]) r12_l <= r11_l;
    end

    // ---------------- stages 9..12: qhat = hi(c*F), then qhat*(-q)
    mbau_mul u_mul_qhat (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[9]), .i_en_sum(w_ctl.en[10]),
        .i_x(r8_c), .i_y(r_factor), .o_p(w_pe)
    );
    mbau_mul u_mul_qm (
        .i_clk(i_clk), .i_en_pp(w_ctl.en[11]), .i_en_sum(w_ctl.en[12]),
        .i_x(w_pe[PROD_BITS-1:DIGIT_BITS]), .i_y(w_qn), .o_p(w_pf)
    );

    // ---------------- stages 13..16: correction and mode finish
    logic [WORD_BITS-1:0]  w_ms14, w_ms15, w_ms16;
    logic [DIGIT_BITS+1:0] r15_v;
    logic [RES_BITS-1:0]   r16_res;
    t_side                 w_s14, w_s15;

    assign w_s14  = r_side[14];
    assign w_s15  = r_side[15];
    assign w_ms14 = f_min_sub({{(WORD_BITS-DIGIT_BITS){1'b0}}, r13_r}, r_modulus);
    assign w_ms15 = f_min_sub({{(WORD_BITS-DIGIT_BITS){1'b0}}, r14_p}, r_modulus);
    assign w_ms16 = f_min_sub({{(WORD_BITS-DIGIT_BITS-2){1'b0}}, r15_v}, r_modulus);

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[13]) r13_r <= r12_l + w_pf[DIGIT_BITS-1:0];
        if (w_ctl.en[14]) r14_p <= w_ms14[DIGIT_BITS-1:0];
        if (w_ctl.en[15]) begin
            case (w_s14.mode)
                MODE_MUL, MODE_RED64: r15_v <= {2'b0, r14_p};
                MODE_RED_WIDE:        r15_v <= w_ms15[DIGIT_BITS+1:0];
                MODE_MUL_ADD:         r15_v <= {4'b0, w_s14.acc} + {2'b0, r14_p};
                MODE_MUL_SUB:         r15_v <= {4'b0, w_s14.acc} - {2'b0, r14_p};
                MODE_RED_SIGNED:      r15_v <= (w_s14.neg && r14_p != '0)
                                             ? {4'b0, r_modulus - r14_p[RES_BITS-1:0]}
                                             : {2'b0, r14_p};
                MODE_ADD, MODE_SUB, MODE_NEG: r15_v <= {4'b0, w_s14.simple};
                default:              r15_v <= '0;
            endcase
        end
        if (w_ctl.en[16]) begin
            case (w_s15.mode)
                MODE_MUL_ADD: r16_res <= w_ms16[RES_BITS-1:0];
                MODE_MUL_SUB: r16_res <= r15_v[DIGIT_BITS+1]
                                       ? (r15_v[RES_BITS-1:0] + r_modulus)
                                       : r15_v[RES_BITS-1:0];
                default:      r16_res <= r15_v[RES_BITS-1:0];
            endcase
        end
    end

    assign o_out_valid = w_ctl.vld[NSTG-1];
    assign o_result    = r16_res;
    assign o_last_out  = r_side[NSTG-1].last;

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&w_ctl.vld) && i_out_stall) |-> o_in_stall)
        else $error("full pipe accepted a word under stall");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.vld[NSTG-2] && !i_out_stall) |=> o_out_valid)
        else $error("word lost at output stage");
endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the modular Barrett ALU (modq_barrett_alu_50bit_unit).
// Depends on mbau_pkg; predicts each result word in-bench and compares in order.
module tb_top;
    import mbau_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] DMASK = (64'd1 << 52) - 1;
    localparam logic [63:0] HMASK = (64'd1 << 26) - 1;
    localparam logic [63:0] RMASK = (64'd1 << 50) - 1;
    localparam int LATENCY = NSTG;

    typedef struct packed {
        logic [3:0]  mode;
        logic [63:0] a;
        logic [63:0] b;
        logic [49:0] acc;
        logic        last;
    } t_word;

    typedef struct packed {
        logic [49:0] res;
        logic        last;
    } t_res;

    typedef struct {
        t_word w;
        bit    known;
        logic [49:0] res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [3:0] i_mode = '0;
    logic [63:0] i_op_a = '0;
    logic [63:0] i_op_b = '0;
    logic [49:0] i_acc = '0;
    logic i_last_in = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [49:0] o_result;
    logic o_last_out;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [51:0] i_cfg_data = '0;

    modq_barrett_alu_50bit_unit DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the register file
    logic [63:0] q_mod, bar_fac, bar_sh, fold1, fold2;
    t_res expected_q[$];
    int n_err = 0;

    function automatic void mul52(input logic [63:0] x, input logic [63:0] y,
                                  output logic [63:0] lo, output logic [63:0] hi);
        logic [63:0] x0, x1, y0, y1, mid, low;
        x &= DMASK;
        y &= DMASK;
        x0 = x & HMASK; x1 = x >> 26;
        y0 = y & HMASK; y1 = y >> 26;
        mid = x0 * y1 + x1 * y0;
        low = x0 * y0 + ((mid & HMASK) << 26);
        lo = low & DMASK;
        hi = x1 * y1 + (mid >> 26) + (low >> 52);
    endfunction

    function automatic logic [63:0] mlo(input logic [63:0] s, x, y);
        logic [63:0] l, h;
        mul52(x, y, l, h);
        return s + l;
    endfunction

    function automatic logic [63:0] mhi(input logic [63:0] s, x, y);
        logic [63:0] l, h;
        mul52(x, y, l, h);
        return s + h;
    endfunction

    function automatic logic [63:0] shr64(input logic [63:0] x, input logic [63:0] s);
        return (s > 63) ? 64'd0 : x >> s;
    endfunction

    function automatic logic [63:0] shl64(input logic [63:0] x, input logic [63:0] s);
        return (s > 63) ? 64'd0 : x << s;
    endfunction

    function automatic logic [63:0] cond_sub(input logic [63:0] v);
        logic [63:0] w;
        w = v - q_mod;
        return (w < v) ? w : v;
    endfunction

    function automatic logic [63:0] barrett_est(input logic [63:0] c1, input logic [63:0] lo);
        logic [63:0] qh;
        qh = mhi(0, c1, bar_fac);
        return cond_sub(mlo(lo, qh, 64'd0 - q_mod) & DMASK);
    endfunction

    function automatic logic [63:0] red_split(input logic [63:0] hi, input logic [63:0] lo);
        return barrett_est(shr64(lo, bar_sh) | shl64(hi, 64'd52 - bar_sh), lo);
    endfunction

    function automatic logic [63:0] sub_wrap(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] d;
        d = x - y;
        return d[63] ? d + q_mod : d;
    endfunction

    function automatic logic [63:0] mod_prod(input logic [63:0] a, input logic [63:0] b);
        return red_split(mhi(0, a, b), mlo(0, a, b));
    endfunction

    function automatic t_res predict_alu(input t_word w);
        logic [63:0] r, x0, x1, x2, sh, sl, h2, l2, h3, l3, na;
        t_res o;
        r = 0;
        case (w.mode)
            MODE_MUL:     r = mod_prod(w.a, w.b);
            MODE_MUL_ADD: r = cond_sub({14'd0, w.acc} + mod_prod(w.a, w.b));
            MODE_MUL_SUB: r = sub_wrap({14'd0, w.acc}, mod_prod(w.a, w.b));
            MODE_ADD:     r = cond_sub(w.a + w.b);
            MODE_SUB:     r = sub_wrap(w.a, w.b);
            MODE_NEG:     r = (w.a == 0) ? 64'd0 : q_mod - w.a;
            MODE_RED64:   r = barrett_est(shr64(w.a, bar_sh), w.a);
            MODE_RED_SIGNED: begin
                na = w.a[63] ? 64'd0 - w.a : w.a;
                r = barrett_est(shr64(na, bar_sh), na);
                if (w.a[63] && r != 0) r = q_mod - r;
            end
            MODE_RED_WIDE: begin
                x0 = w.a & DMASK;
                x1 = (w.a >> 52) | ((w.b & 64'hFF_FFFF_FFFF) << 12);
                x2 = w.b >> 40;
                sh = mhi(0, x1, fold1);
                sl = mlo(x0, x1, fold1);
                sh = mhi(sh, x2, fold2);
                sl = mlo(sl, x2, fold2);
                sh += sl >> 52;
                sl &= DMASK;
                h2 = mhi(0, sh, fold1);
                l2 = mlo(sl, sh, fold1);
                h3 = mhi(0, h2, fold1);
                l3 = mlo(l2, h2, fold1);
                h3 += l3 >> 52;
                l3 &= DMASK;
                r = cond_sub(red_split(h3, l3));
            end
            default: r = 0;
        endcase
        o.res = r[49:0];
        o.last = w.last;
        return o;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[51:0];
        case (idx)
            CFG_MODULUS:  q_mod = val & RMASK;
            CFG_FACTOR:   bar_fac = val & DMASK;
            CFG_SHIFT:    bar_sh = val & 64'd63;
            CFG_FOLD_ONE: fold1 = val & RMASK;
            default:      fold2 = val & RMASK;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // 2^k mod q by repeated doubling
    function automatic logic [63:0] pow2_mod(input int k, input logic [63:0] q);
        logic [63:0] v;
        v = 1 % q;
        for (int i = 0; i < k; i++) v = (v << 1) % q;
        return v;
    endfunction

    // program a full, consistent Barrett setting for modulus q
    task automatic program_modulus(input logic [63:0] q);
        int nb;
        logic [127:0] num;
        nb = $clog2(q + 1);
        num = 128'd1 << (nb + 51);
        write_reg(CFG_MODULUS, q);
        write_reg(CFG_FACTOR, 64'((num / q) & DMASK));
        write_reg(CFG_SHIFT, 64'(nb - 1));
        write_reg(CFG_FOLD_ONE, pow2_mod(52, q));
        write_reg(CFG_FOLD_TWO, pow2_mod(104, q));
    endtask

    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (extra) @(posedge i_clk);
    endtask

    bit burst_on = 1'b1;
    int burst_left = 0;

    // valid stays up between words of a burst; it drops only in a gap
    task automatic send_word(input t_word w);
        int gap;
        while (burst_left == 0) begin
            if (burst_on) begin
                burst_left = $urandom_range(1, 40);
                burst_on = 1'b0;
            end else begin
                gap = $urandom_range(0, 5);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_on = 1'b1;
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode <= w.mode;
        i_op_a <= w.a;
        i_op_b <= w.b;
        i_acc <= w.acc;
        i_last_in <= w.last;
        expected_q.push_back(predict_alu(w));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // receiver stall pattern: alternating quiet and choppy windows
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 600 < 200) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected word: result=%h last=%b",
                                          o_result, o_last_out);
            end else begin
                e = expected_q.pop_front();
                if (e.res !== o_result || e.last !== o_last_out) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp %h/%b got %h/%b",
                                 e.res, e.last, o_result, o_last_out);
                end
            end
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rnd_below(input logic [63:0] q);
        return rnd64() % q;
    endfunction

    function automatic t_word rand_word(input logic [63:0] q);
        t_word w;
        int pick;
        w.mode = 4'($urandom_range(0, 8));
        pick = $urandom_range(0, 19);
        if (pick == 0) w.mode = 4'($urandom_range(9, 15));
        w.a = rnd_below(q);
        w.b = rnd_below(q);
        w.acc = 50'(rnd_below(q));
        if (w.mode inside {MODE_RED64, MODE_RED_SIGNED, MODE_RED_WIDE} || pick == 1) begin
            w.a = rnd64();
            if (w.mode == MODE_RED_WIDE || pick == 1) w.b = rnd64();
        end
        if (pick == 2) w.acc = 50'(rnd64());
        w.last = 1'($urandom_range(0, 1));
        return w;
    endfunction

    t_row rows[$];
    logic [63:0] qlist[4] = '{64'd3, 64'd1125899906842597, 64'd65537, 64'd1099511627791};

    task automatic add_row(input logic [3:0] m, input logic [63:0] a, b,
                           input logic [49:0] acc, input logic last,
                           input bit known, input logic [49:0] res);
        t_row r;
        r.w = '{m, a, b, acc, last};
        r.known = known;
        r.res = res;
        rows.push_back(r);
    endtask

    initial begin
        t_res p;
        q_mod = 2; bar_fac = 0; bar_sh = 0; fold1 = 0; fold2 = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // right after reset: q = 2, nothing else programmed
        add_row(MODE_ADD, 64'd1, 64'd1, 0, 1'b1, 1'b1, 50'd0);
        add_row(MODE_NEG, 64'd1, 64'd0, 0, 1'b0, 1'b1, 50'd1);
        add_row(MODE_NEG, 64'd0, 64'd0, 0, 1'b1, 1'b1, 50'd0);
        add_row(4'd15, '1, '1, '1, 1'b1, 1'b1, 50'd0);
        foreach (rows[i]) begin
            p = predict_alu(rows[i].w);
            if (rows[i].known && p.res !== rows[i].res) begin
                n_err++;
                $display("table row %0d disagrees with predictor", i);
            end
            send_word(rows[i].w);
        end
        drain(LATENCY + 4);

        // directed extremes with a real prime near 2^50
        program_modulus(qlist[1]);
        rows.delete();
        for (int m = 0; m <= 8; m++)
            add_row(4'(m), qlist[1] - 1, qlist[1] - 1, 50'(qlist[1] - 1), m[0], 1'b0, 0);
        add_row(MODE_RED64, '1, 0, 0, 1'b0, 1'b0, 0);
        add_row(MODE_RED_SIGNED, 64'h8000_0000_0000_0000, 0, 0, 1'b1, 1'b0, 0);
        add_row(MODE_RED_SIGNED, '1, 0, 0, 1'b0, 1'b0, 0);
        add_row(MODE_RED_WIDE, '1, '1, 0, 1'b1, 1'b0, 0);
        add_row(MODE_SUB, 0, qlist[1] - 1, 0, 1'b0, 1'b0, 0);
        add_row(MODE_MUL, '1, '1, '1, 1'b1, 1'b0, 0);
        add_row(MODE_MUL_SUB, 0, 0, 0, 1'b0, 1'b0, 0);
        add_row(4'd9, 0, 0, 0, 1'b1, 1'b0, 0);
        foreach (rows[i]) send_word(rows[i].w);
        drain(LATENCY + 4);

        // odd shift extremes: above 52 and at 52
        write_reg(CFG_SHIFT, 64'd63);
        for (int i = 0; i < 20; i++) send_word(rand_word(qlist[1]));
        drain(LATENCY + 4);
        write_reg(CFG_SHIFT, 64'd52);
        write_reg(CFG_FACTOR, DMASK);
        write_reg(CFG_FOLD_ONE, RMASK);
        write_reg(CFG_FOLD_TWO, RMASK);
        for (int i = 0; i < 20; i++) send_word(rand_word(qlist[1]));
        drain(LATENCY + 4);
        write_reg(CFG_MODULUS, 64'd2);
        write_reg(CFG_FACTOR, 64'd0);
        write_reg(CFG_SHIFT, 64'd0);
        write_reg(CFG_FOLD_ONE, 64'd0);
        write_reg(CFG_FOLD_TWO, 64'd0);
        for (int i = 0; i < 20; i++) send_word(rand_word(64'd2));
        drain(LATENCY + 4);

        // random phases over several moduli
        for (int ph = 0; ph < 4; ph++) begin
            program_modulus(qlist[ph]);
            for (int i = 0; i < 310; i++) send_word(rand_word(qlist[ph]));
            drain(LATENCY + 4);
        end

        drain(LATENCY + 8);
        if (n_err == 0) $display("tb_top: clean");
        else $display("tb_top: errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== modq_barrett_alu_50bit_unit.f =====
src/mbau_pkg.sv
src/mbau_mul.sv
src/mbau_ctl.sv
src/modq_barrett_alu_50bit_unit.sv
test/tb_top.sv
